// ----- src/assert_macros.svh -----
// Assertion macros used by the port-level checker of the point cover block.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpc check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define CPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpc check failed: next-cycle implication");

`endif

// ----- src/cpc_pkg.sv -----
// Shared constants, codes and control types of the convex polygon point cover block.
// Depends on nothing; used by every other file of the block but the assertion macros header.
package cpc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 24;

    localparam int VADDR_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W    = 7;
    localparam int CMP_W    = CNT_W + VADDR_W + 1;
    localparam int VERT_W   = 2 * COORD_BITS;
    localparam int TOL_W    = 48;
    localparam int OPND_W   = COORD_BITS + 1;
    localparam int PROD_W   = 2 * OPND_W;
    localparam int TERM_W   = PROD_W + 1;
    localparam int ACC_W    = PROD_W + VADDR_W + 2;
    localparam int FIN_W    = ACC_W + 1;
    localparam int FINCMP_W = (FIN_W > TOL_W) ? FIN_W : TOL_W;
    localparam int MIN_RING = 3;

    // Request codes carried by req_type.
    localparam logic [1:0] REQ_OUTER = 2'd0;
    localparam logic [1:0] REQ_INNER = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_OUTER_COUNT = 2'd0;
    localparam logic [1:0] CFG_INNER_COUNT = 2'd1;
    localparam logic [1:0] CFG_TOLERANCE   = 2'd2;

    typedef enum logic [1:0] {
        OPS_DIFF_B,
        OPS_DIFF_C,
        OPS_BY_CX,
        OPS_BX_CY
    } opsel_t;

    typedef enum logic [1:0] {
        TERM_HOLD,
        TERM_LOAD,
        TERM_SUB
    } term_op_t;

    typedef enum logic [2:0] {
        FIN_HOLD,
        FIN_SHOE_ABS,
        FIN_DIFF,
        FIN_ABS,
        FIN_CMP
    } fin_op_t;

    typedef struct packed {
        opsel_t   opsel;
        term_op_t term_op;
        logic     acc_clear;
        logic     tri_add;
        logic     shoe_add;
        logic     shoe_sub;
        fin_op_t  fin_op;
    } ctl_t;

endpackage

// ----- src/cpc_edge_unit.sv -----
// Shared multiply-accumulate unit: one signed multiplier, edge term, ring sums and final compare.
// Depends on cpc_pkg for widths and the control struct.
module cpc_edge_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cpc_pkg::ctl_t                          ctl,
    input  logic signed [cpc_pkg::COORD_BITS-1:0]  b_x,
    input  logic signed [cpc_pkg::COORD_BITS-1:0]  b_y,
    input  logic signed [cpc_pkg::COORD_BITS-1:0]  c_x,
    input  logic signed [cpc_pkg::COORD_BITS-1:0]  c_y,
    input  logic signed [cpc_pkg::COORD_BITS-1:0]  p_x,
    input  logic signed [cpc_pkg::COORD_BITS-1:0]  p_y,
    input  logic        [cpc_pkg::TOL_W-1:0]       tol,
    output logic                                   match
);

    logic signed [cpc_pkg::OPND_W-1:0] opa_reg;
    logic signed [cpc_pkg::OPND_W-1:0] opb_reg;
    logic signed [cpc_pkg::OPND_W-1:0] opa_next;
    logic signed [cpc_pkg::OPND_W-1:0] opb_next;
    logic signed [cpc_pkg::PROD_W-1:0] prod_reg;
    logic signed [cpc_pkg::TERM_W-1:0] term_reg;
    logic        [cpc_pkg::TERM_W-1:0] term_mag;
    logic        [cpc_pkg::ACC_W-1:0]  tri_reg;
    logic signed [cpc_pkg::ACC_W-1:0]  shoe_reg;
    logic signed [cpc_pkg::FIN_W-1:0]  fin_reg;
    logic                              match_reg;

    // Operand selection: point-relative differences for the triangle term,
    // raw coordinates for the shoelace term.
    always_comb
    begin
        case (ctl.opsel)
            cpc_pkg::OPS_DIFF_B:
            begin
                opa_next = cpc_pkg::OPND_W'(b_x) - cpc_pkg::OPND_W'(p_x);
                opb_next = cpc_pkg::OPND_W'(c_y) - cpc_pkg::OPND_W'(p_y);
            end
            cpc_pkg::OPS_DIFF_C:
            begin
                opa_next = cpc_pkg::OPND_W'(c_x) - cpc_pkg::OPND_W'(p_x);
                opb_next = cpc_pkg::OPND_W'(b_y) - cpc_pkg::OPND_W'(p_y);
            end
            cpc_pkg::OPS_BY_CX:
            begin
                opa_next = cpc_pkg::OPND_W'(b_y);
                opb_next = cpc_pkg::OPND_W'(c_x);
            end
            cpc_pkg::OPS_BX_CY:
            begin
                opa_next = cpc_pkg::OPND_W'(b_x);
                opb_next = cpc_pkg::OPND_W'(c_y);
            end
            default:
            begin
                opa_next = '0;
                opb_next = '0;
            end
        endcase
    end

    assign term_mag = term_reg[cpc_pkg::TERM_W-1] ? cpc_pkg::TERM_W'(-term_reg)
                                                  : cpc_pkg::TERM_W'(term_reg);

    always_ff @(posedge clk)
    begin
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        prod_reg <= opa_reg * opb_reg;

        case (ctl.term_op)
            cpc_pkg::TERM_LOAD: term_reg <= cpc_pkg::TERM_W'(prod_reg);
            cpc_pkg::TERM_SUB:  term_reg <= term_reg - cpc_pkg::TERM_W'(prod_reg);
            default:            term_reg <= term_reg;
        endcase

        if (ctl.acc_clear)
        begin
            tri_reg  <= '0;
            shoe_reg <= '0;
        end
        else
        begin
            if (ctl.tri_add)
            begin
                tri_reg <= tri_reg + cpc_pkg::ACC_W'(term_mag);
            end
            if (ctl.shoe_add)
            begin
                shoe_reg <= shoe_reg + cpc_pkg::ACC_W'(prod_reg);
            end
            else if (ctl.shoe_sub)
            begin
                shoe_reg <= shoe_reg - cpc_pkg::ACC_W'(prod_reg);
            end
        end

        case (ctl.fin_op)
            cpc_pkg::FIN_SHOE_ABS:
            begin
                fin_reg <= shoe_reg[cpc_pkg::ACC_W-1] ? -cpc_pkg::FIN_W'(shoe_reg)
                                                      : cpc_pkg::FIN_W'(shoe_reg);
            end
            cpc_pkg::FIN_DIFF: fin_reg <= $signed({1'b0, tri_reg}) - fin_reg;
            cpc_pkg::FIN_ABS:  fin_reg <= fin_reg[cpc_pkg::FIN_W-1] ? -fin_reg : fin_reg;
            default:           fin_reg <= fin_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctl.fin_op == cpc_pkg::FIN_CMP)
        begin
            match_reg <= cpc_pkg::FINCMP_W'($unsigned(fin_reg))
                         <= cpc_pkg::FINCMP_W'(tol);
        end
    end

    assign match = match_reg;

endmodule

// ----- src/convex_polygon_point_cover_unit.sv -----
// Top level of the convex polygon point cover block: vertex stores, configuration and sequencer.
// Depends on cpc_pkg and cpc_edge_unit.
//
// Usage. An item is presented on req_type, vertex_index, coord_x and coord_y with start
// high; it is taken at a rising edge where busy is low. A load item (outer or inner
// vertex) is written in that cycle, causes no result and leaves busy low, so loads can
// follow back to back. A query item raises busy and walks the outer ring, then the hole
// ring if the outer ring matched and the hole has three or more vertices.
// Each edge is worked in phases, paced by the single shared 25 x 25 multiplier, which forms
// four products per edge, and by the one-port vertex read. A ring walk goes through the priming
// states, its edges, a drain state, the final states and a decide state, and the hole ring, if
// walked, goes through the same steps. An outer ring of fewer than three vertices gives a
// result in the cycle after the query.
// The result is shown on covered for one cycle with done high, just as busy falls; the
// receiver cannot stall and must take it then. The user writes configuration through cfg_valid,
// cfg_index and cfg_data (cfg_ready is always high) only while the block is idle, though
// the block itself does not enforce it. Reset clears the counts, the tolerance and the sequencer;
// vertex stores keep no reset value and must be written before they are queried.
module convex_polygon_point_cover_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic        [1:0]                      req_type,
    input  logic        [5:0]                      vertex_index,
    input  logic signed [cpc_pkg::COORD_BITS-1:0]  coord_x,
    input  logic signed [cpc_pkg::COORD_BITS-1:0]  coord_y,
    output logic                                   done,
    output logic                                   covered,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [1:0]                      cfg_index,
    input  logic        [cpc_pkg::TOL_W-1:0]       cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRIME,
        S_FIRST,
        S_WAIT,
        S_EDGE,
        S_DRAIN,
        S_FIN0,
        S_FIN1,
        S_FIN2,
        S_FIN3,
        S_DECIDE
    } state_t;

    localparam int CB = cpc_pkg::COORD_BITS;

    state_t                        state_reg;
    logic [2:0]                    ph_reg;
    logic                          ring_reg;
    logic [cpc_pkg::VADDR_W-1:0]   edge_reg;
    logic [cpc_pkg::VADDR_W-1:0]   vidx_reg;
    logic                          done_reg;
    logic                          covered_reg;

    logic [cpc_pkg::CNT_W-1:0]     outer_count_reg;
    logic [cpc_pkg::CNT_W-1:0]     inner_count_reg;
    logic [cpc_pkg::TOL_W-1:0]     tol_reg;

    logic [cpc_pkg::VERT_W-1:0]    outer_mem [cpc_pkg::MAX_VERTICES];
    logic [cpc_pkg::VERT_W-1:0]    inner_mem [cpc_pkg::MAX_VERTICES];
    logic [cpc_pkg::VERT_W-1:0]    outer_rd_reg;
    logic [cpc_pkg::VERT_W-1:0]    inner_rd_reg;
    logic [cpc_pkg::VERT_W-1:0]    rd_vert;

    logic [cpc_pkg::VERT_W-1:0]    b_reg;
    logic [cpc_pkg::VERT_W-1:0]    c_reg;
    logic [cpc_pkg::VERT_W-1:0]    first_reg;
    logic signed [CB-1:0]          px_reg;
    logic signed [CB-1:0]          py_reg;

    logic                          accept;
    logic                          in_range;
    logic                          wr_outer;
    logic                          wr_inner;
    logic [cpc_pkg::VADDR_W-1:0]   wr_addr;
    logic [cpc_pkg::VERT_W-1:0]    wr_data;
    logic [cpc_pkg::CMP_W-1:0]     outer_n;
    logic [cpc_pkg::CMP_W-1:0]     inner_n;
    logic [cpc_pkg::CMP_W-1:0]     n_cur;
    logic                          last_edge;
    logic                          match;
    cpc_pkg::ctl_t                 ctl;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign covered   = covered_reg;

    assign in_range = cpc_pkg::CMP_W'(vertex_index) < cpc_pkg::CMP_W'(cpc_pkg::MAX_VERTICES);
    assign wr_outer = accept && (req_type == cpc_pkg::REQ_OUTER) && in_range;
    assign wr_inner = accept && (req_type == cpc_pkg::REQ_INNER) && in_range;
    assign wr_addr  = cpc_pkg::VADDR_W'(vertex_index);
    assign wr_data  = {coord_y, coord_x};

    // Counts above the store depth are saturated to it.
    assign outer_n = (cpc_pkg::CMP_W'(outer_count_reg) > cpc_pkg::CMP_W'(cpc_pkg::MAX_VERTICES))
                     ? cpc_pkg::CMP_W'(cpc_pkg::MAX_VERTICES) : cpc_pkg::CMP_W'(outer_count_reg);
    assign inner_n = (cpc_pkg::CMP_W'(inner_count_reg) > cpc_pkg::CMP_W'(cpc_pkg::MAX_VERTICES))
                     ? cpc_pkg::CMP_W'(cpc_pkg::MAX_VERTICES) : cpc_pkg::CMP_W'(inner_count_reg);
    assign n_cur     = ring_reg ? inner_n : outer_n;
    assign last_edge = (cpc_pkg::CMP_W'(edge_reg) + cpc_pkg::CMP_W'(1)) == n_cur;
    assign rd_vert   = ring_reg ? inner_rd_reg : outer_rd_reg;

    // Vertex stores: one write and one registered read each per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_outer)
        begin
            outer_mem[wr_addr] <= wr_data;
        end
        if (wr_inner)
        begin
            inner_mem[wr_addr] <= wr_data;
        end
        outer_rd_reg <= outer_mem[vidx_reg];
        inner_rd_reg <= inner_mem[vidx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_count_reg <= '0;
            inner_count_reg <= '0;
            tol_reg         <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cpc_pkg::CFG_OUTER_COUNT: outer_count_reg <= cfg_data[cpc_pkg::CNT_W-1:0];
                cpc_pkg::CFG_INNER_COUNT: inner_count_reg <= cfg_data[cpc_pkg::CNT_W-1:0];
                cpc_pkg::CFG_TOLERANCE:   tol_reg         <= cfg_data;
                default:                  tol_reg         <= tol_reg;
            endcase
        end
    end

    // Edge operands and the query point.
    always_ff @(posedge clk)
    begin
        if (accept && (req_type == cpc_pkg::REQ_QUERY))
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (state_reg == S_FIRST)
        begin
            b_reg     <= rd_vert;
            first_reg <= rd_vert;
        end
        if ((state_reg == S_EDGE) && (ph_reg == 3'd0))
        begin
            c_reg <= last_edge ? first_reg : rd_vert;
        end
        if ((state_reg == S_EDGE) && (ph_reg == 3'd5))
        begin
            b_reg <= c_reg;
        end
    end

    // Per-edge schedule: phase 0 takes the far vertex, phases 1 to 4 feed the multiplier through the
    // operand and product registers, and the triangle term and shoelace products fold in after them.
    always_comb
    begin
        ctl = '{opsel: cpc_pkg::OPS_DIFF_B, term_op: cpc_pkg::TERM_HOLD, acc_clear: 1'b0,
                tri_add: 1'b0, shoe_add: 1'b0, shoe_sub: 1'b0, fin_op: cpc_pkg::FIN_HOLD};
        case (state_reg)
            S_FIRST: ctl.acc_clear = 1'b1;
            S_EDGE:
            begin
                case (ph_reg)
                    3'd0: ctl.shoe_sub = (edge_reg != '0);
                    3'd1: ctl.opsel = cpc_pkg::OPS_DIFF_B;
                    3'd2: ctl.opsel = cpc_pkg::OPS_DIFF_C;
                    3'd3:
                    begin
                        ctl.opsel   = cpc_pkg::OPS_BY_CX;
                        ctl.term_op = cpc_pkg::TERM_LOAD;
                    end
                    3'd4:
                    begin
                        ctl.opsel   = cpc_pkg::OPS_BX_CY;
                        ctl.term_op = cpc_pkg::TERM_SUB;
                    end
                    3'd5:
                    begin
                        ctl.tri_add  = 1'b1;
                        ctl.shoe_add = 1'b1;
                    end
                    default: ctl.term_op = cpc_pkg::TERM_HOLD;
                endcase
            end
            S_DRAIN: ctl.shoe_sub = 1'b1;
            S_FIN0:  ctl.fin_op = cpc_pkg::FIN_SHOE_ABS;
            S_FIN1:  ctl.fin_op = cpc_pkg::FIN_DIFF;
            S_FIN2:  ctl.fin_op = cpc_pkg::FIN_ABS;
            S_FIN3:  ctl.fin_op = cpc_pkg::FIN_CMP;
            default: ctl.fin_op = cpc_pkg::FIN_HOLD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ph_reg      <= '0;
            ring_reg    <= 1'b0;
            edge_reg    <= '0;
            vidx_reg    <= '0;
            done_reg    <= 1'b0;
            covered_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (req_type == cpc_pkg::REQ_QUERY))
                    begin
                        if (outer_n >= cpc_pkg::CMP_W'(cpc_pkg::MIN_RING))
                        begin
                            ring_reg  <= 1'b0;
                            vidx_reg  <= '0;
                            state_reg <= S_PRIME;
                        end
                        else
                        begin
                            covered_reg <= 1'b0;
                            done_reg    <= 1'b1;
                        end
                    end
                end
                S_PRIME: state_reg <= S_FIRST;
                S_FIRST:
                begin
                    vidx_reg  <= cpc_pkg::VADDR_W'(1);
                    edge_reg  <= '0;
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    ph_reg    <= '0;
                    state_reg <= S_EDGE;
                end
                S_EDGE:
                begin
                    if (ph_reg == 3'd0)
                    begin
                        vidx_reg <= vidx_reg + cpc_pkg::VADDR_W'(1);
                    end
                    if (ph_reg == 3'd5)
                    begin
                        ph_reg <= '0;
                        if (last_edge)
                        begin
                            state_reg <= S_DRAIN;
                        end
                        else
                        begin
                            edge_reg <= edge_reg + cpc_pkg::VADDR_W'(1);
                        end
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                end
                S_DRAIN: state_reg <= S_FIN0;
                S_FIN0:  state_reg <= S_FIN1;
                S_FIN1:  state_reg <= S_FIN2;
                S_FIN2:  state_reg <= S_FIN3;
                S_FIN3:  state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    if (ring_reg)
                    begin
                        covered_reg <= !match;
                        done_reg    <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                    else if (!match)
                    begin
                        covered_reg <= 1'b0;
                        done_reg    <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                    else if (inner_n >= cpc_pkg::CMP_W'(cpc_pkg::MIN_RING))
                    begin
                        ring_reg  <= 1'b1;
                        vidx_reg  <= '0;
                        state_reg <= S_PRIME;
                    end
                    else
                    begin
                        covered_reg <= 1'b1;
                        done_reg    <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    cpc_edge_unit u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .b_x   ($signed(b_reg[CB-1:0])),
        .b_y   ($signed(b_reg[2*CB-1:CB])),
        .c_x   ($signed(c_reg[CB-1:0])),
        .c_y   ($signed(c_reg[2*CB-1:CB])),
        .p_x   (px_reg),
        .p_y   (py_reg),
        .tol   (tol_reg),
        .match (match)
    );

endmodule

// ----- src/cpc_checker.sv -----
// Port-level checker of the convex polygon point cover block, bound to the top level.
// Depends on cpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cpc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] req_type,
    input logic       done
);

    logic take_query;
    logic take_other;

    assign take_query = start && !busy && (req_type == cpc_pkg::REQ_QUERY);
    assign take_other = start && !busy && (req_type != cpc_pkg::REQ_QUERY);

    // A result is only ever shown once the block has gone idle.
    `CPC_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    // A query either answers at once or starts its ring walk.
    `CPC_ASSERT_NEXT(a_query_acts, clk, rst_n, take_query, done || busy)
    // Load items and unused codes neither answer nor occupy the block.
    `CPC_ASSERT_NEXT(a_load_silent, clk, rst_n, take_other, !done && !busy)
    // Finishing a walk always delivers its result.
    `CPC_ASSERT_NOW(a_end_result, clk, rst_n, $fell(busy), done)

endmodule

bind convex_polygon_point_cover_unit cpc_checker u_cpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .done     (done)
);

// ----- verif/cpc_cover_checker.sv -----
// Scoreboard for the convex polygon point cover unit: mirrors the vertex stores and the
// registers, predicts the covered flag of every query and checks it at done.
// Depends on cpc_pkg; instantiated beside the unit by tb_top.
module cpc_cover_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic [1:0]                         req_type,
    input  logic [5:0]                         vertex_index,
    input  logic [cpc_pkg::COORD_BITS-1:0]     coord_x,
    input  logic [cpc_pkg::COORD_BITS-1:0]     coord_y,
    input  logic                               done,
    input  logic                               covered,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [cpc_pkg::TOL_W-1:0]          cfg_data,
    output int                                 fail_count,
    output int                                 outstanding,
    output int                                 queries_checked,
    output int                                 covered_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import cpc_pkg::*;

    typedef struct packed {
        logic                          covered;
        logic signed [COORD_BITS-1:0]  px;
        logic signed [COORD_BITS-1:0]  py;
    } cover_due_t;

    cover_due_t        cover_due_q[$];
    cover_due_t        due;
    logic [VERT_W-1:0] outer_store [MAX_VERTICES];
    logic [VERT_W-1:0] inner_store [MAX_VERTICES];
    logic [CNT_W-1:0]  outer_cnt;
    logic [CNT_W-1:0]  inner_cnt;
    logic [TOL_W-1:0]  tolerance;

    // Sum of the doubled triangle areas against the doubled shoelace area of one ring.
    function automatic logic ring_matches(input logic hole, input int n,
                                          input longint px, input longint py);
        longint            tri_sum;
        longint            shoe;
        longint            t;
        longint            bx;
        longint            by;
        longint            cx;
        longint            cy;
        longint            diff;
        logic [VERT_W-1:0] vb;
        logic [VERT_W-1:0] vc;
        int                i;
        int                j;
        tri_sum = 0;
        shoe    = 0;
        for (i = 0; i < n; i++)
        begin
            j  = (i + 1 == n) ? 0 : i + 1;
            vb = hole ? inner_store[i] : outer_store[i];
            vc = hole ? inner_store[j] : outer_store[j];
            bx = $signed(vb[COORD_BITS-1:0]);
            by = $signed(vb[VERT_W-1:COORD_BITS]);
            cx = $signed(vc[COORD_BITS-1:0]);
            cy = $signed(vc[VERT_W-1:COORD_BITS]);
            t  = bx * cy - cx * by + py * cx - px * cy + px * by - py * bx;
            tri_sum += (t < 0) ? -t : t;
            shoe    += by * cx - bx * cy;
        end
        if (shoe < 0)
            shoe = -shoe;
        diff = (tri_sum > shoe) ? tri_sum - shoe : shoe - tri_sum;
        return diff <= longint'(tolerance);
    endfunction

    function automatic logic predict_cover(input longint px, input longint py);
        int on;
        int inn;
        on  = (outer_cnt > MAX_VERTICES) ? MAX_VERTICES : int'(outer_cnt);
        inn = (inner_cnt > MAX_VERTICES) ? MAX_VERTICES : int'(inner_cnt);
        if (on < MIN_RING || !ring_matches(1'b0, on, px, py))
            return 1'b0;
        if (inn >= MIN_RING && ring_matches(1'b1, inn, px, py))
            return 1'b0;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cover_due_q.delete();
            outer_cnt       = '0;
            inner_cnt       = '0;
            tolerance       = '0;
            fail_count      = 0;
            queries_checked = 0;
            covered_count   = 0;
            outstanding    <= 0;
        end
        else
        begin
            if (done)
            begin
                if (cover_due_q.size() == 0)
                begin
                    $error("covered: result %0b arrived with no query waiting", covered);
                    fail_count++;
                end
                else
                begin
                    due = cover_due_q.pop_front();
                    queries_checked++;
                    if (covered !== due.covered)
                    begin
                        $error("covered mismatch for point (%0d, %0d): expected %0b, actual %0b",
                               due.px, due.py, due.covered, covered);
                        fail_count++;
                    end
                    else if (covered)
                        covered_count++;
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_OUTER_COUNT: outer_cnt = cfg_data[CNT_W-1:0];
                    CFG_INNER_COUNT: inner_cnt = cfg_data[CNT_W-1:0];
                    CFG_TOLERANCE:   tolerance = cfg_data;
                    default:         ;
                endcase
            end

            if (start && !busy)
            begin
                case (req_type)
                    REQ_OUTER: outer_store[vertex_index] = {coord_y, coord_x};
                    REQ_INNER: inner_store[vertex_index] = {coord_y, coord_x};
                    REQ_QUERY:
                    begin
                        due.px      = coord_x;
                        due.py      = coord_y;
                        due.covered = predict_cover($signed(coord_x), $signed(coord_y));
                        cover_due_q.push_back(due);
                    end
                    default:   ;
                endcase
            end

            outstanding <= cover_due_q.size();
        end
    end

endmodule

// ----- verif/tb_top.sv -----
// Top of the point cover testbench: clock, reset, vertex loads, queries and register
// writes with random gaps, and the verdict. Depends on cpc_pkg, cpc_cover_checker and
// convex_polygon_point_cover_unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cpc_pkg::*;

    localparam int         ITEM_TARGET   = 1550;
    localparam int         CYCLE_LIMIT   = 6_000_000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         DRAIN_CYCLES  = 800;
    localparam int         C_MAX         = (1 << (COORD_BITS - 1)) - 1;
    localparam int         C_MIN         = -(1 << (COORD_BITS - 1));
    localparam logic [1:0] REQ_NONE      = 2'd3;
    localparam logic [1:0] CFG_NONE      = 2'd3;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [1:0]                    req_type;
    logic [5:0]                    vertex_index;
    logic signed [COORD_BITS-1:0]  coord_x;
    logic signed [COORD_BITS-1:0]  coord_y;
    logic                          done;
    logic                          covered;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [1:0]                    cfg_index;
    logic [TOL_W-1:0]              cfg_data;

    int          fail_count;
    int          outstanding;
    int          queries_checked;
    int          covered_count;
    int unsigned cycle_count = 0;
    int          items_sent;
    int          phases;
    bit          burst;

    // What the unit's vertex stores hold, used to aim queries at the rings.
    int ring_x [0:1][0:MAX_VERTICES-1];
    int ring_y [0:1][0:MAX_VERTICES-1];

    always #4 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    convex_polygon_point_cover_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .done         (done),
        .covered      (covered),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    cpc_cover_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .vertex_index    (vertex_index),
        .coord_x         (coord_x),
        .coord_y         (coord_y),
        .done            (done),
        .covered         (covered),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .queries_checked (queries_checked),
        .covered_count   (covered_count)
    );

    function automatic int pick_gap();
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 48);
    endfunction

    function automatic int draw_vertex_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return $urandom_range(0, 2);
        if (r < 14)
            return MAX_VERTICES;
        if (r < 20)
            return $urandom_range(MAX_VERTICES + 1, 127);
        if (r < 30)
            return $urandom_range(11, 40);
        return $urandom_range(3, 10);
    endfunction

    // Returns at the edge where the item is taken, with start still high.
    task automatic send_item(input logic [1:0] req, input int idx, input int x, input int y);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        req_type     <= req;
        vertex_index <= idx[5:0];
        coord_x      <= x[COORD_BITS-1:0];
        coord_y      <= y[COORD_BITS-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (req != REQ_NONE)
            items_sent++;
    endtask

    task automatic load_vertex(input int ring, input int idx, input int x, input int y);
        send_item(ring ? REQ_INNER : REQ_OUTER, idx, x, y);
        ring_x[ring][idx] = x;
        ring_y[ring][idx] = y;
    endtask

    // Registers are only written once every query has returned its result.
    task automatic cfg_write(input logic [1:0] idx, input logic [TOL_W-1:0] data);
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic cfg_count(input logic [1:0] idx, input int n);
        logic [TOL_W-1:0] junk;
        logic [CNT_W-1:0] cnt_bits;
        junk     = TOL_W'({$urandom, $urandom});
        cnt_bits = n[CNT_W-1:0];
        if ($urandom_range(0, 1))
            junk = '0;
        cfg_write(idx, {junk[TOL_W-1:CNT_W], cnt_bits});
    endtask

    // Vertices on a parabola, taken in slot order, always form a strictly convex ring.
    task automatic build_ring(input int ring, input int n, input int cx, input int cy,
                              input int sx, input int ky);
        int u;
        int x0;
        int y0;
        int tmp;
        int k;
        int slot;
        bit swap;
        bit negx;
        bit negy;
        bit down;
        swap = ($urandom_range(0, 1) != 0);
        negx = ($urandom_range(0, 1) != 0);
        negy = ($urandom_range(0, 1) != 0);
        down = ($urandom_range(0, 1) != 0);
        for (k = 0; k < n; k++)
        begin
            slot = down ? n - 1 - k : k;
            u    = 2 * slot - (n - 1);
            x0   = u * sx;
            y0   = u * u * ky;
            if (swap)
            begin
                tmp = x0;
                x0  = y0;
                y0  = tmp;
            end
            if (negx)
                x0 = -x0;
            if (negy)
                y0 = -y0;
            load_vertex(ring, slot, cx + x0, cy + y0);
        end
    endtask

    task automatic send_query(input int on, input int inn);
        int r;
        int a;
        int b;
        int c;
        int x;
        int y;
        r = $urandom_range(0, 99);
        a = $urandom_range(0, on - 1);
        b = $urandom_range(0, on - 1);
        c = $urandom_range(0, on - 1);
        if (r < 25)
        begin
            x = ring_x[0][a];
            y = ring_y[0][a];
        end
        else if (r < 35)
        begin
            // Midpoint of an edge: on the boundary, or just off it after rounding.
            b = (a + 1) % on;
            x = (ring_x[0][a] + ring_x[0][b]) / 2;
            y = (ring_y[0][a] + ring_y[0][b]) / 2;
        end
        else if (r < 55)
        begin
            x = (ring_x[0][a] + ring_x[0][b] + ring_x[0][c]) / 3;
            y = (ring_y[0][a] + ring_y[0][b] + ring_y[0][c]) / 3;
        end
        else if (r < 70)
        begin
            a = $urandom_range(0, inn - 1);
            b = $urandom_range(0, inn - 1);
            c = $urandom_range(0, inn - 1);
            x = (ring_x[1][a] + ring_x[1][b] + ring_x[1][c]) / 3;
            y = (ring_y[1][a] + ring_y[1][b] + ring_y[1][c]) / 3;
        end
        else if (r < 88)
        begin
            x = ring_x[0][a] + $urandom_range(0, 512) - 256;
            y = ring_y[0][a] + $urandom_range(0, 512) - 256;
        end
        else
        begin
            x = $urandom;
            y = $urandom;
        end
        send_item(REQ_QUERY, $urandom_range(0, 63), x, y);
    endtask

    task automatic run_directed();
        // No outer ring configured yet.
        send_item(REQ_QUERY, 0, 0, 0);
        cfg_write(CFG_OUTER_COUNT, TOL_W'(3));
        load_vertex(0, 0, C_MIN, C_MIN);
        load_vertex(0, 1, C_MAX, C_MIN);
        load_vertex(0, 2, 0, C_MAX);
        send_item(REQ_QUERY, 63, 0, 0);
        send_item(REQ_QUERY, 0, C_MIN, C_MIN);
        send_item(REQ_QUERY, 0, C_MAX, C_MIN);
        send_item(REQ_QUERY, 0, C_MAX, C_MAX);
        send_item(REQ_QUERY, 0, C_MIN, C_MAX);
        send_item(REQ_NONE, 63, C_MAX, C_MIN);
        cfg_write(CFG_INNER_COUNT, TOL_W'(3));
        load_vertex(1, 0, -256, -256);
        load_vertex(1, 1, 256, -256);
        load_vertex(1, 2, 0, 256);
        load_vertex(1, 63, C_MAX, C_MAX);
        send_item(REQ_QUERY, 0, 0, 0);
        send_item(REQ_QUERY, 0, 0, -4000000);
        cfg_write(CFG_TOLERANCE, '1);
        send_item(REQ_QUERY, 0, C_MAX, C_MAX);
        // An index past the register list must change nothing.
        cfg_write(CFG_NONE, '1);
        cfg_write(CFG_OUTER_COUNT, TOL_W'(2));
        send_item(REQ_QUERY, 0, 0, 0);
        cfg_write(CFG_OUTER_COUNT, TOL_W'(1));
        cfg_write(CFG_INNER_COUNT, '0);
        cfg_write(CFG_TOLERANCE, '0);
        send_item(REQ_QUERY, 0, 0, 0);
    endtask

    task automatic run_phase(input int p);
        int               oc;
        int               ic;
        int               on;
        int               inn;
        int               k;
        int               n_items;
        int               r;
        int               ring;
        int               lim;
        int               slot;
        int               sx;
        int               ky;
        longint           sum_x;
        longint           sum_y;
        logic [TOL_W-1:0] tol;
        oc = draw_vertex_count();
        ic = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : draw_vertex_count();
        r  = $urandom_range(0, 99);
        if (r < 40)
            tol = '0;
        else if (r < 60)
            tol = TOL_W'($urandom_range(0, 255));
        else if (r < 75)
            tol = TOL_W'($urandom);
        else if (r < 85)
            tol = '1;
        else
            tol = TOL_W'({$urandom, $urandom});
        case (p)
            0:
            begin
                oc  = 127;
                ic  = MAX_VERTICES;
                tol = '0;
            end
            1:
            begin
                oc  = MAX_VERTICES;
                ic  = 0;
                tol = '1;
            end
            2:
            begin
                oc  = 3;
                ic  = 3;
                tol = '0;
            end
            3:
            begin
                oc = MAX_VERTICES + 1;
                ic = 127;
            end
            default: ;
        endcase
        burst = ($urandom_range(0, 4) == 0);

        cfg_count(CFG_OUTER_COUNT, oc);
        cfg_count(CFG_INNER_COUNT, ic);
        cfg_write(CFG_TOLERANCE, tol);

        // Every slot that a query can read is written, even for rings too short to count.
        on  = (oc > MAX_VERTICES) ? MAX_VERTICES : ((oc < MIN_RING) ? MIN_RING : oc);
        inn = (ic > MAX_VERTICES) ? MAX_VERTICES : ((ic < MIN_RING) ? MIN_RING : ic);
        if ($urandom_range(0, 9) < 3)
        begin
            sx = $urandom_range(1, 8);
            ky = $urandom_range(1, 4);
        end
        else
        begin
            sx = $urandom_range(1, 60000);
            ky = $urandom_range(1, 1500);
        end
        build_ring(0, on, $urandom_range(0, 800000) - 400000,
                   $urandom_range(0, 800000) - 400000, sx, ky);
        sum_x = 0;
        sum_y = 0;
        for (k = 0; k < on; k++)
        begin
            sum_x += ring_x[0][k];
            sum_y += ring_y[0][k];
        end
        build_ring(1, inn, int'(sum_x / on), int'(sum_y / on),
                   $urandom_range(1, (sx / 8 > 1) ? sx / 8 : 1),
                   $urandom_range(1, (ky / 8 > 1) ? ky / 8 : 1));

        n_items = $urandom_range(20, 50);
        for (k = 0; k < n_items; k++)
        begin
            r    = $urandom_range(0, 99);
            ring = $urandom_range(0, 1);
            lim  = ring ? inn : on;
            if (r < 62)
                send_query(on, inn);
            else if (r < 80 || (r < 92 && lim == MAX_VERTICES))
            begin
                // Rewrite a ring vertex, sometimes nudged so the ring may lose convexity.
                slot = $urandom_range(0, lim - 1);
                load_vertex(ring, slot, ring_x[ring][slot] + $urandom_range(0, 2) - 1,
                            ring_y[ring][slot] + $urandom_range(0, 2) - 1);
            end
            else if (r < 92)
                load_vertex(ring, $urandom_range(lim, MAX_VERTICES - 1), $urandom, $urandom);
            else
                send_item(REQ_NONE, $urandom_range(0, 63), $urandom, $urandom);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = REQ_OUTER;
        vertex_index = '0;
        coord_x      = '0;
        coord_y      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_OUTER_COUNT;
        cfg_data     = '0;
        items_sent   = 0;
        phases       = 0;
        burst        = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        while (items_sent < ITEM_TARGET)
        begin
            run_phase(phases);
            phases++;
        end

        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d load and query items over %0d random register settings;",
                 items_sent, phases);
        $display("checked %0d query results, %0d of them covered.",
                 queries_checked, covered_count);
        if (fail_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Run stopped at the cycle limit with %0d results outstanding.", outstanding);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
